// ----- rtl/suffix_automaton_builder_macros.svh -----
// Assertion macros for the suffix automaton builder.
`ifndef SUFFIX_AUTOMATON_BUILDER_MACROS_SVH
`define SUFFIX_AUTOMATON_BUILDER_MACROS_SVH
`ifndef NO_ASSERTIONS
`define SAB_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define SAB_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define SAB_ASSERT(label, prop, msg)
`define SAB_ASSERT_ALWAYS(label, prop, msg)
`endif
`endif

// ----- rtl/sab_pkg.sv -----
// Shared constants and sequencer state type of the suffix automaton builder.
package sab_pkg;
  localparam int NODE_CAPACITY = 131072;
  localparam int ALPHABET_SIZE = 26;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_LEN_RD,
    ST_LEN_WR,
    ST_W1_RD,
    ST_W1_CHK,
    ST_PLEN_RD,
    ST_TLEN_RD,
    ST_CMP,
    ST_CL_LINK,
    ST_COPY,
    ST_COPY_END,
    ST_W2_RD,
    ST_W2_CHK,
    ST_FIX1,
    ST_FIX2
  } state_t;
endpackage

// ----- rtl/sab_ram.sv -----
// Single write port, single registered read port memory.
module sab_ram #(
  parameter int AW = 17,
  parameter int DW = 17
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [DW-1:0] wdata,
  input  logic [AW-1:0] raddr,
  output logic [DW-1:0] rdata
);
  logic [DW-1:0] mem [2**AW];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end
endmodule

// ----- rtl/suffix_automaton_builder.sv -----
// Top level: sequencer of the suffix automaton extension over three memories.
// Usage:
//   Drive symbol and starts_string with start high; the item is taken at a
//   rising edge where start is high and busy is low. busy then stays high
//   until the item is finished.
//   In the first cycle with busy low again, done is high for exactly one cycle
//   with distinct_count (running count of distinct substrings) and store_full.
//   The receiver cannot stall: a result is gone after its one strobe cycle.
// Sequence (busy high throughout, every item ends in FIX2):
//   LEN_RD, LEN_WR set the new node's length; the suffix-link walk (W1_RD,
//   W1_CHK) ends the item at the null node; else PLEN_RD, TLEN_RD, CMP end it
//   when the target's length matches; else a clone: CL_LINK, COPY of its row
//   through the single read port of the transition memory, COPY_END, the second
//   walk (W2_RD, W2_CHK) and FIX1. Rejected items go straight to FIX2.
// Reset:
//   rst (synchronous) starts a clearing pass that writes zero over the
//   transition, length and link memories, one entry a cycle, until every
//   transition address has been written. busy is high for the whole pass.
`include "suffix_automaton_builder_macros.svh"
module suffix_automaton_builder #(
  parameter int NODE_CAPACITY = sab_pkg::NODE_CAPACITY,
  parameter int ALPHABET_SIZE = sab_pkg::ALPHABET_SIZE
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [4:0]  symbol,
  input  logic        starts_string,
  output logic        done,
  output logic [31:0] distinct_count,
  output logic        store_full
);
  localparam int NW  = $clog2(NODE_CAPACITY);
  localparam int CW  = (ALPHABET_SIZE > 1) ? $clog2(ALPHABET_SIZE) : 1;
  localparam int TAW = NW + CW;
  localparam logic [NW-1:0] ROOT = NW'(1);
  localparam logic [NW-1:0] NONE = '0;

  sab_pkg::state_t state, state_next;

  logic [TAW:0]    clr;
  logic [NW-1:0]   cnt, last, prev, fresh, target, copy;
  logic [NW-1:0]   flen, lp1, linklen;
  logic [CW-1:0]   cidx, kread, kwr;
  logic            kvld, skip, full_f;
  logic [31:0]     total;

  logic            t_we, l_we, k_we;
  logic [TAW-1:0]  t_wa, t_ra;
  logic [NW-1:0]   t_wd, t_rd;
  logic [NW-1:0]   l_wa, l_wd, l_ra, l_rd;
  logic [NW-1:0]   k_wa, k_wd, k_ra, k_rd;

  logic            accept, bad_sym, no_room;

  assign accept  = start && (state == sab_pkg::ST_IDLE);
  assign bad_sym = {4'b0, symbol} >= 9'(ALPHABET_SIZE);
  assign no_room = ({1'b0, cnt} + (NW+1)'(2)) >= (NW+1)'(NODE_CAPACITY);
  assign busy    = (state != sab_pkg::ST_IDLE);

  sab_ram #(.AW(TAW), .DW(NW)) u_trans (
    .clk(clk), .we(t_we), .waddr(t_wa), .wdata(t_wd), .raddr(t_ra), .rdata(t_rd)
  );
  sab_ram #(.AW(NW), .DW(NW)) u_len (
    .clk(clk), .we(l_we), .waddr(l_wa), .wdata(l_wd), .raddr(l_ra), .rdata(l_rd)
  );
  sab_ram #(.AW(NW), .DW(NW)) u_link (
    .clk(clk), .we(k_we), .waddr(k_wa), .wdata(k_wd), .raddr(k_ra), .rdata(k_rd)
  );

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      sab_pkg::ST_CLEAR:    if (clr[TAW]) state_next = sab_pkg::ST_IDLE;
      sab_pkg::ST_IDLE: begin
        if (start) begin
          state_next = (bad_sym || no_room) ? sab_pkg::ST_FIX2 : sab_pkg::ST_LEN_RD;
        end
      end
      sab_pkg::ST_LEN_RD:   state_next = sab_pkg::ST_LEN_WR;
      sab_pkg::ST_LEN_WR:   state_next = sab_pkg::ST_W1_RD;
      sab_pkg::ST_W1_RD:    state_next = (prev == NONE) ? sab_pkg::ST_FIX2 : sab_pkg::ST_W1_CHK;
      sab_pkg::ST_W1_CHK:   state_next = (t_rd == NONE) ? sab_pkg::ST_W1_RD : sab_pkg::ST_PLEN_RD;
      sab_pkg::ST_PLEN_RD:  state_next = sab_pkg::ST_TLEN_RD;
      sab_pkg::ST_TLEN_RD:  state_next = sab_pkg::ST_CMP;
      sab_pkg::ST_CMP:      state_next = (l_rd == lp1) ? sab_pkg::ST_FIX2 : sab_pkg::ST_CL_LINK;
      sab_pkg::ST_CL_LINK:  state_next = sab_pkg::ST_COPY;
      sab_pkg::ST_COPY: begin
        if (kread == CW'(ALPHABET_SIZE - 1)) state_next = sab_pkg::ST_COPY_END;
      end
      sab_pkg::ST_COPY_END: state_next = sab_pkg::ST_W2_RD;
      sab_pkg::ST_W2_RD:    state_next = (prev == NONE) ? sab_pkg::ST_FIX1 : sab_pkg::ST_W2_CHK;
      sab_pkg::ST_W2_CHK:   state_next = (t_rd == target) ? sab_pkg::ST_W2_RD : sab_pkg::ST_FIX1;
      sab_pkg::ST_FIX1:     state_next = sab_pkg::ST_FIX2;
      // FIX2 also closes every item: fixes target's link after a clone
      sab_pkg::ST_FIX2:     state_next = sab_pkg::ST_IDLE;
      default:              state_next = sab_pkg::ST_IDLE;
    endcase
  end

  // Memory controls
  always_comb begin
    t_we = 1'b0; t_wa = '0; t_wd = '0; t_ra = {prev, cidx};
    l_we = 1'b0; l_wa = '0; l_wd = '0; l_ra = prev;
    k_we = 1'b0; k_wa = '0; k_wd = '0; k_ra = prev;
    unique case (state)
      sab_pkg::ST_CLEAR: begin
        t_we = 1'b1; t_wa = clr[TAW-1:0];
        l_we = 1'b1; l_wa = clr[NW-1:0];
        k_we = 1'b1; k_wa = clr[NW-1:0];
      end
      sab_pkg::ST_LEN_WR: begin
        l_we = 1'b1; l_wa = fresh; l_wd = l_rd + NW'(1);
      end
      sab_pkg::ST_W1_RD: begin
        if (prev == NONE) begin
          k_we = 1'b1; k_wa = fresh; k_wd = ROOT;
        end
      end
      sab_pkg::ST_W1_CHK: begin
        if (t_rd == NONE) begin
          t_we = 1'b1; t_wa = {prev, cidx}; t_wd = fresh;
        end
      end
      sab_pkg::ST_TLEN_RD: l_ra = target;
      sab_pkg::ST_CMP: begin
        k_ra = target;
        if (l_rd == lp1) begin
          k_we = 1'b1; k_wa = fresh; k_wd = target;
        end else begin
          l_we = 1'b1; l_wa = cnt + NW'(1); l_wd = lp1;
        end
      end
      sab_pkg::ST_CL_LINK: begin
        k_we = 1'b1; k_wa = copy; k_wd = k_rd;
      end
      sab_pkg::ST_COPY: begin
        t_ra = {target, kread};
        if (kvld) begin
          t_we = 1'b1; t_wa = {copy, kwr}; t_wd = t_rd;
        end
      end
      sab_pkg::ST_COPY_END: begin
        t_we = 1'b1; t_wa = {copy, kwr}; t_wd = t_rd;
      end
      sab_pkg::ST_W2_CHK: begin
        if (t_rd == target) begin
          t_we = 1'b1; t_wa = {prev, cidx}; t_wd = copy;
        end
      end
      sab_pkg::ST_FIX1: begin
        k_we = 1'b1; k_wa = fresh; k_wd = copy;
      end
      sab_pkg::ST_FIX2: begin
        if (!skip && copy != NONE) begin
          k_we = 1'b1; k_wa = target; k_wd = copy;
        end
      end
      default: begin
      end
    endcase
  end

  // Control and datapath registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= sab_pkg::ST_CLEAR;
      clr    <= '0;
      cnt    <= ROOT;
      last   <= ROOT;
      total  <= '0;
      done   <= 1'b0;
      kvld   <= 1'b0;
      skip   <= 1'b0;
      full_f <= 1'b0;
      copy   <= NONE;
    end else begin
      state <= state_next;
      done  <= 1'b0;
      unique case (state)
        sab_pkg::ST_CLEAR: clr <= clr + (TAW+1)'(1);
        sab_pkg::ST_IDLE: begin
          if (accept) begin
            skip   <= bad_sym || no_room;
            full_f <= !bad_sym && no_room;
            cidx   <= CW'(symbol);
            copy   <= NONE;
            if (!(bad_sym || no_room)) begin
              prev  <= starts_string ? ROOT : last;
              fresh <= cnt + NW'(1);
              cnt   <= cnt + NW'(1);
            end
          end
        end
        sab_pkg::ST_LEN_WR: flen <= l_rd + NW'(1);
        sab_pkg::ST_W1_RD: if (prev == NONE) linklen <= '0;
        sab_pkg::ST_W1_CHK: begin
          if (t_rd == NONE) begin
            prev <= k_rd;
          end else begin
            target <= t_rd;
          end
        end
        sab_pkg::ST_TLEN_RD: lp1 <= l_rd + NW'(1);
        sab_pkg::ST_CMP: begin
          linklen <= lp1;
          if (l_rd != lp1) begin
            copy <= cnt + NW'(1);
            cnt  <= cnt + NW'(1);
          end
        end
        sab_pkg::ST_CL_LINK: begin
          kread <= '0;
          kvld  <= 1'b0;
        end
        sab_pkg::ST_COPY: begin
          kwr   <= kread;
          kvld  <= 1'b1;
          kread <= kread + CW'(1);
        end
        sab_pkg::ST_COPY_END: kvld <= 1'b0;
        sab_pkg::ST_W2_CHK: if (t_rd == target) prev <= k_rd;
        sab_pkg::ST_FIX2: begin
          done       <= 1'b1;
          store_full <= full_f;
          if (skip) begin
            distinct_count <= total;
          end else begin
            total          <= total + 32'(flen - linklen);
            distinct_count <= total + 32'(flen - linklen);
            last           <= fresh;
          end
        end
        default: begin
        end
      endcase
    end
  end

  `SAB_ASSERT(a_done_one_cycle, done |=> !done, "result strobe longer than one cycle")
  `SAB_ASSERT(a_done_after_busy, done |-> $past(busy), "result without a transaction in work")
  `SAB_ASSERT(a_cnt_in_range, {1'b0, cnt} < (NW+1)'(NODE_CAPACITY), "node counter past capacity")
  `SAB_ASSERT_ALWAYS(a_reset_busy, rst |=> busy, "block not busy after reset")
endmodule

// ----- tb/sab_checker.sv -----
// Checker: tracks accepted transactions, predicts results and compares them.
module sab_checker #(
  parameter int CAP = 2048
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic        busy,
  input  logic [4:0]  symbol,
  input  logic        starts_string,
  input  logic        done,
  input  logic [31:0] distinct_count,
  input  logic        store_full,
  output int          fail_count,
  output int          pending
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [31:0] total;
    logic        full;
  } count_t;

  int unsigned trans [CAP][sab_pkg::ALPHABET_SIZE];
  int unsigned nlen [CAP];
  int unsigned slink [CAP];
  int unsigned node_top;
  int unsigned tail;
  logic [31:0] total;
  count_t      counts_due [$];

  initial begin
    fail_count = 0;
    node_top = 1;
    tail = 1;
    total = '0;
    foreach (trans[i, j]) trans[i][j] = 0;
    foreach (nlen[i]) begin
      nlen[i] = 0;
      slink[i] = 0;
    end
  end

  assign pending = counts_due.size();

  // Run one suffix automaton extension and return the new count.
  function automatic count_t add_symbol(logic [4:0] c, logic fresh_str);
    count_t r;
    int unsigned p, cur, q, cl;
    r.full = 1'b0;
    if (c >= sab_pkg::ALPHABET_SIZE) begin
      r.total = total;
      return r;
    end
    if (node_top + 2 >= CAP) begin
      r.total = total;
      r.full = 1'b1;
      return r;
    end
    if (fresh_str) tail = 1;
    p = tail;
    cur = ++node_top;
    nlen[cur] = nlen[p] + 1;
    while (p != 0 && trans[p][c] == 0) begin
      trans[p][c] = cur;
      p = slink[p];
    end
    if (p == 0) begin
      slink[cur] = 1;
    end else begin
      q = trans[p][c];
      if (nlen[q] == nlen[p] + 1) begin
        slink[cur] = q;
      end else begin
        cl = ++node_top;
        nlen[cl] = nlen[p] + 1;
        slink[cl] = slink[q];
        for (int k = 0; k < sab_pkg::ALPHABET_SIZE; k++) trans[cl][k] = trans[q][k];
        while (p != 0 && trans[p][c] == q) begin
          trans[p][c] = cl;
          p = slink[p];
        end
        slink[cur] = cl;
        slink[q] = cl;
      end
    end
    total = total + (nlen[cur] - nlen[slink[cur]]);
    tail = cur;
    r.total = total;
    return r;
  endfunction

  always @(posedge clk) begin
    count_t want;
    if (!rst) begin
      if (done) begin
        if (counts_due.size() == 0) begin
          $error("result with no transaction pending");
          fail_count++;
        end else begin
          want = counts_due.pop_front();
          if (distinct_count !== want.total) begin
            $error("distinct_count: expected %0d, got %0d", want.total, distinct_count);
            fail_count++;
          end
          if (store_full !== want.full) begin
            $error("store_full: expected %0b, got %0b", want.full, store_full);
            fail_count++;
          end
        end
      end
      if (start && !busy) counts_due.push_back(add_symbol(symbol, starts_string));
    end
  end
endmodule

// ----- tb/tb_top.sv -----
// Testbench top: clock, reset, stimulus and verdict for the suffix automaton builder.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CAP = 2048;
  localparam int WATCHDOG = 200000;
  localparam int RANDOM_ITEMS = 1620;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        start = 1'b0;
  logic [4:0]  symbol = '0;
  logic        starts_string = 1'b0;
  logic        busy, done, store_full;
  logic [31:0] distinct_count;
  int          fail_count, pending;
  int          idle_cycles = 0;
  int          burst_left = 0;

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  suffix_automaton_builder #(.NODE_CAPACITY(CAP)) dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .symbol(symbol),
    .starts_string(starts_string), .done(done), .distinct_count(distinct_count),
    .store_full(store_full)
  );

  sab_checker #(.CAP(CAP)) chk (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .symbol(symbol),
    .starts_string(starts_string), .done(done), .distinct_count(distinct_count),
    .store_full(store_full), .fail_count(fail_count), .pending(pending)
  );

  always @(posedge clk) begin
    if (rst || (start && !busy) || done) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // Hold one transaction until accepted; drop start after a burst ends.
  task automatic push_symbol(logic [4:0] c, logic fresh_str);
    symbol <= c;
    starts_string <= fresh_str;
    start <= 1'b1;
    do @(negedge clk); while (busy);
    @(posedge clk);
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      start <= 1'b0;
      repeat ($urandom_range(0, 12)) @(posedge clk);
      burst_left = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 20);
    end
  endtask

  task automatic drain();
    start <= 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (200) @(posedge clk);
  endtask

  initial begin
    int sent;
    int len, span;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    // Directed: extremes, out-of-alphabet symbols, clone-forcing strings.
    push_symbol(5'd0, 1'b1);
    push_symbol(5'd0, 1'b0);
    push_symbol(5'd1, 1'b0);
    push_symbol(5'd1, 1'b0);
    push_symbol(5'd25, 1'b0);
    push_symbol(5'd26, 1'b1);
    push_symbol(5'd31, 1'b0);
    push_symbol(5'd30, 1'b1);
    push_symbol(5'd1, 1'b1);
    push_symbol(5'd0, 1'b0);
    push_symbol(5'd1, 1'b0);
    push_symbol(5'd25, 1'b1);
    push_symbol(5'd25, 1'b0);
    push_symbol(5'd0, 1'b1);
    push_symbol(5'd1, 1'b0);
    push_symbol(5'd0, 1'b0);
    push_symbol(5'd15, 1'b0);
    drain();
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      if ($urandom_range(0, 9) == 0) begin
        push_symbol(5'($urandom_range(0, 31)), 1'($urandom_range(0, 1)));
        sent++;
      end else begin
        // Small alphabets give repeats and therefore clones.
        len = $urandom_range(1, 14);
        span = $urandom_range(0, 7) == 0 ? 25 : $urandom_range(1, 3);
        for (int k = 0; k < len; k++) begin
          push_symbol(5'($urandom_range(0, span)), k == 0);
          sent++;
        end
      end
      if (sent >= RANDOM_ITEMS / 2 && sent < RANDOM_ITEMS / 2 + 15) drain();
    end
    drain();
    if (fail_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end
endmodule
